// File: src/blm_pkg.sv
// Package for the battery level monitor: widths, codes, reset values and
// the command/status structs shared by controller and datapath.
// No dependencies.
package blm_pkg;

  localparam int RawW      = 12;
  localparam int LevelW    = 28;
  localparam int AlphaW    = 16;
  localparam int ThreshW   = 16;
  localparam int CountW    = 4;
  localparam int SumW      = 16;
  localparam int StatusW   = 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int FracW     = 16;
  localparam int ThreshSh  = 12;
  localparam int DiffW     = LevelW + 1;
  localparam int ProdW     = DiffW + AlphaW + 1;
  localparam int DivSteps  = SumW + FracW;
  localparam int DivCntW   = $clog2(DivSteps);

  localparam int PrimeAttemptsDef = 10;

  localparam logic [AlphaW-1:0]  AlphaRst = AlphaW'(3277);
  localparam logic [RawW-1:0]    MinRst   = RawW'(565);
  localparam logic [RawW-1:0]    MaxRst   = RawW'(1692);
  localparam logic [ThreshW-1:0] LowRst   = ThreshW'(18952);
  localparam logic [ThreshW-1:0] CritRst  = ThreshW'(17147);
  localparam logic [RawW-1:0]    RawBad   = '1;

  typedef logic [RawW-1:0]     raw_t;
  typedef logic [LevelW-1:0]   level_t;
  typedef logic [CountW-1:0]   count_t;

  typedef enum logic [StatusW-1:0] {
    ST_UPDATED = 3'd0,
    ST_PRIMING = 3'd1,
    ST_PRIMED  = 3'd2,
    ST_INVALID = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALPHA = 3'd0,
    CFG_MIN   = 3'd1,
    CFG_MAX   = 3'd2,
    CFG_LOW   = 3'd3,
    CFG_CRIT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_MUL,
    S_ADD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic div_step;
    logic mul;
    logic add;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_div;
    logic go_ema;
    logic div_last;
  } dp_stat_t;

endpackage

// File: src/blm_in_if.sv
// Input sample channel: valid/ready plus one ADC conversion per beat.
// Depends on blm_pkg.
interface blm_in_if;
  logic              valid;
  logic              ready;
  blm_pkg::raw_t     raw_sample;
  logic              conversion_ok;

  modport source (output valid, output raw_sample, output conversion_ok, input ready);
  modport sink   (input valid, input raw_sample, input conversion_ok, output ready);
endinterface

// File: src/blm_out_if.sv
// Result channel: valid/ready plus status, filtered level and flags per beat.
// Depends on blm_pkg.
interface blm_out_if;
  logic                         valid;
  logic                         ready;
  logic [blm_pkg::StatusW-1:0]  status;
  blm_pkg::level_t              filtered_level;
  logic                         low_flag;
  logic                         critical_flag;
  logic                         ready_res;

  modport source (output valid, output status, output filtered_level, output low_flag,
                  output critical_flag, output ready_res, input ready);
  modport sink   (input valid, input status, input filtered_level, input low_flag,
                  input critical_flag, input ready_res, output ready);
endinterface

// File: src/blm_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on blm_pkg.
interface blm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [blm_pkg::CfgIdxW-1:0]   index;
  logic [blm_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/blm_datapath.sv
// Datapath: config registers, priming accumulators, restoring divider,
// filter update multiply/add and the result register. Depends on blm_pkg.
module blm_datapath #(
  parameter int PRIME_ATTEMPTS = blm_pkg::PrimeAttemptsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  blm_pkg::ctrl_cmd_t            cmd,
  output blm_pkg::dp_stat_t             stat,
  input  blm_pkg::raw_t                 in_raw,
  input  logic                          in_ok,
  input  logic                          cfg_we,
  input  logic [blm_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [blm_pkg::CfgDataW-1:0]  cfg_data,
  output logic [blm_pkg::StatusW-1:0]   out_status,
  output blm_pkg::level_t               out_level,
  output logic                          out_low,
  output logic                          out_crit,
  output logic                          out_primed
);

  localparam blm_pkg::count_t PrimeN = blm_pkg::CountW'(PRIME_ATTEMPTS);

  // configuration
  logic [blm_pkg::AlphaW-1:0]  alpha_r;
  blm_pkg::raw_t               min_r, max_r;
  logic [blm_pkg::ThreshW-1:0] low_r, crit_r;

  // block state
  blm_pkg::count_t             attempt_r, valid_r;
  logic [blm_pkg::SumW-1:0]    sum_r;
  blm_pkg::level_t             filt_r;
  logic                        primed_r;

  // per-item working registers
  blm_pkg::raw_t               raw_r;
  logic                        ok_r;
  blm_pkg::status_t            status_r;
  logic [blm_pkg::DivSteps-1:0] divq_r;
  logic [blm_pkg::CountW-1:0]  rem_r;
  logic [blm_pkg::DivCntW-1:0] divcnt_r;
  logic signed [blm_pkg::DiffW-1:0] diff_r;
  logic signed [blm_pkg::ProdW-1:0] prod_r;

  // result register
  blm_pkg::status_t            ostat_r;
  blm_pkg::level_t             olevel_r;
  logic                        olow_r, ocrit_r, oprimed_r;

  // item classification
  logic                        priming, last, invalid, out_rng;
  logic [blm_pkg::SumW-1:0]    sum_upd;
  blm_pkg::count_t             cnt_upd, att_upd;
  logic [blm_pkg::CountW:0]    rem_sh;
  logic                        ge;

  always_comb begin
    priming = attempt_r < PrimeN;
    sum_upd = sum_r + (ok_r ? blm_pkg::SumW'(raw_r) : '0);
    cnt_upd = valid_r + blm_pkg::CountW'(ok_r);
    att_upd = attempt_r + blm_pkg::CountW'(1);
    last    = att_upd >= PrimeN;
    invalid = !ok_r || (raw_r == '0) || (raw_r == blm_pkg::RawBad);
    out_rng = (raw_r < min_r) || (raw_r > max_r);
    stat.go_div   = priming && last && (cnt_upd != '0);
    stat.go_ema   = !priming && !invalid && !out_rng && primed_r;
    stat.div_last = divcnt_r == blm_pkg::DivCntW'(blm_pkg::DivSteps - 1);
    rem_sh = {rem_r, divq_r[blm_pkg::DivSteps-1]};
    ge     = rem_sh >= {1'b0, valid_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= blm_pkg::AlphaRst;
      min_r   <= blm_pkg::MinRst;
      max_r   <= blm_pkg::MaxRst;
      low_r   <= blm_pkg::LowRst;
      crit_r  <= blm_pkg::CritRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        blm_pkg::CFG_ALPHA: alpha_r <= cfg_data;
        blm_pkg::CFG_MIN:   min_r   <= cfg_data[blm_pkg::RawW-1:0];
        blm_pkg::CFG_MAX:   max_r   <= cfg_data[blm_pkg::RawW-1:0];
        blm_pkg::CFG_LOW:   low_r   <= cfg_data;
        blm_pkg::CFG_CRIT:  crit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attempt_r <= '0;
      valid_r   <= '0;
      sum_r     <= '0;
      filt_r    <= '0;
      primed_r  <= 1'b0;
    end else begin
      if (cmd.eval && priming) begin
        sum_r     <= sum_upd;
        valid_r   <= cnt_upd;
        attempt_r <= att_upd;
        if (last && (cnt_upd == '0)) begin
          filt_r   <= '0;
          primed_r <= 1'b0;
        end
      end else if (cmd.eval && !invalid && !out_rng && !primed_r) begin
        // unprimed: the sample replaces the level
        filt_r <= {raw_r, blm_pkg::FracW'(0)};
      end
      if (cmd.div_step && stat.div_last) begin
        filt_r   <= {divq_r[blm_pkg::LevelW-2:0], ge};
        primed_r <= 1'b1;
      end
      if (cmd.add) begin
        filt_r <= filt_r + prod_r[blm_pkg::LevelW+blm_pkg::FracW-1:blm_pkg::FracW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      raw_r <= in_raw;
      ok_r  <= in_ok;
    end
    if (cmd.eval) begin
      priority if (priming) begin
        status_r <= last ? blm_pkg::ST_PRIMED : blm_pkg::ST_PRIMING;
      end else if (invalid) begin
        status_r <= blm_pkg::ST_INVALID;
      end else if (out_rng) begin
        status_r <= blm_pkg::ST_RANGE;
      end else begin
        status_r <= blm_pkg::ST_UPDATED;
      end
      divq_r   <= {sum_upd, blm_pkg::FracW'(0)};
      rem_r    <= '0;
      divcnt_r <= '0;
      diff_r   <= $signed({1'b0, raw_r, blm_pkg::FracW'(0)}) - $signed({1'b0, filt_r});
    end
    if (cmd.div_step) begin
      rem_r    <= ge ? blm_pkg::CountW'(rem_sh - {1'b0, valid_r})
                     : rem_sh[blm_pkg::CountW-1:0];
      divq_r   <= {divq_r[blm_pkg::DivSteps-2:0], ge};
      divcnt_r <= divcnt_r + blm_pkg::DivCntW'(1);
    end
    if (cmd.mul) begin
      prod_r <= diff_r * $signed({1'b0, alpha_r});
    end
    if (cmd.load_out) begin
      ostat_r   <= status_r;
      olevel_r  <= filt_r;
      olow_r    <= filt_r < {low_r, blm_pkg::ThreshSh'(0)};
      ocrit_r   <= filt_r < {crit_r, blm_pkg::ThreshSh'(0)};
      oprimed_r <= primed_r;
    end
  end

  assign out_status = ostat_r;
  assign out_level  = olevel_r;
  assign out_low    = olow_r;
  assign out_crit   = ocrit_r;
  assign out_primed = oprimed_r;

`ifndef NO_ASSERTIONS
  a_attempt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    attempt_r <= PrimeN)
    else $error("attempt count ran past the priming length");
  a_primed_after_priming: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |-> attempt_r == PrimeN)
    else $error("primed while priming attempts remain");
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < valid_r)
    else $error("divider remainder not below divisor");
`endif

endmodule

// File: src/blm_ctrl.sv
// Controller: sequences accept, evaluate, divide or multiply/add, and
// result load; owns in_ready and out_valid. Depends on blm_pkg.
module blm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  blm_pkg::dp_stat_t   stat,
  output blm_pkg::ctrl_cmd_t  cmd
);

  blm_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      blm_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = blm_pkg::S_EVAL;
      end
      blm_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
        priority if (stat.go_div) state_nxt = blm_pkg::S_DIV;
        else if (stat.go_ema)     state_nxt = blm_pkg::S_MUL;
        else                      state_nxt = blm_pkg::S_DONE;
      end
      blm_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = blm_pkg::S_DONE;
      end
      blm_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = blm_pkg::S_ADD;
      end
      blm_pkg::S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = blm_pkg::S_DONE;
      end
      blm_pkg::S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = blm_pkg::S_IDLE;
        end
      end
      default: state_nxt = blm_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == blm_pkg::S_EVAL)
    else $error("accepted beat not evaluated next cycle");
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == blm_pkg::S_DIV && stat.div_last) |=> state_r == blm_pkg::S_DONE)
    else $error("division did not end after its last step");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == blm_pkg::S_DONE)
    else $error("result raised outside the done state");
`endif

endmodule

// File: src/battery_level_monitor_unit.sv
// Battery level monitor top level: wires the channels to controller and datapath.
// Depends on blm_pkg, blm_in_if, blm_out_if, blm_cfg_if, blm_ctrl, blm_datapath.
//
// Filters 12-bit battery ADC samples into a level in raw counts with 16
// fraction bits and raises low and critical flags against Q4 thresholds.
// One result beat leaves for every input beat. The first PRIME_ATTEMPTS beats
// prime the filter with the mean of the good conversions; after that each good,
// in-range sample moves the level by alpha_q16/65536 of the gap. An accepted beat
// passes the evaluate and done states on its way to the result register for a
// priming attempt, a rejected sample or a sample that replaces an unprimed level;
// a filter update adds multiply and add states (difference, one 29x17 multiply,
// add), and the final priming attempt with at least one good conversion adds the
// restoring divider, which makes one quotient bit per cycle over 32 bits. A result
// still waiting in the output register holds the next item in its done state
// until that beat is taken. in_bus.ready is high only while no item is in flight,
// so the next beat is taken the cycle after its predecessor's result lands in the
// output register, even if that result has not been taken yet. Configuration
// writes belong to idle periods; the block itself does not enforce this.
module battery_level_monitor_unit #(
  parameter int PRIME_ATTEMPTS = blm_pkg::PrimeAttemptsDef
) (
  input  logic     clk,
  input  logic     rst_n,
  blm_in_if.sink   in_bus,
  blm_out_if.source out_bus,
  blm_cfg_if.sink  cfg_bus
);

  blm_pkg::ctrl_cmd_t cmd;
  blm_pkg::dp_stat_t  stat;

  // config writes never stall
  assign cfg_bus.ready = 1'b1;

  blm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  blm_datapath #(
    .PRIME_ATTEMPTS (PRIME_ATTEMPTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_raw     (in_bus.raw_sample),
    .in_ok      (in_bus.conversion_ok),
    .cfg_we     (cfg_bus.valid),
    .cfg_idx    (cfg_bus.index),
    .cfg_data   (cfg_bus.data),
    .out_status (out_bus.status),
    .out_level  (out_bus.filtered_level),
    .out_low    (out_bus.low_flag),
    .out_crit   (out_bus.critical_flag),
    .out_primed (out_bus.ready_res)
  );

endmodule
